/* design/wc_pkg.sv */
// wc_pkg: widths, payload types, controller states and command struct
// for the weighted centroid block. Depends on nothing.
`default_nettype none

package wc_pkg;

  localparam int COORD_BITS  = 11;
  localparam int BRIGHT_BITS = 8;
  localparam int FRAC_BITS   = 8;
  localparam int OUT_BITS    = 19;
  localparam int SUM_XY_BITS = 32;
  localparam int SUM_W_BITS  = 20;
  localparam int PROD_BITS   = COORD_BITS + BRIGHT_BITS;
  localparam int DIVD_BITS   = SUM_XY_BITS + FRAC_BITS;
  localparam int DIV_STEPS   = OUT_BITS;
  localparam int CNT_BITS    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [COORD_BITS-1:0]  pixel_x;
    logic [COORD_BITS-1:0]  pixel_y;
    logic [BRIGHT_BITS-1:0] brightness;
    logic                   last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] centroid_x;
    logic [OUT_BITS-1:0] centroid_y;
    logic                empty_flag;
  } result_t;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_INIT,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic acc;
    logic init;
    logic step;
    logic load;
  } cmd_t;

endpackage

`default_nettype wire

/* design/wc_ifs.sv */
// wc_ifs: valid/ready stream interfaces for pixel items and centroid items.
// Depends on wc_pkg.
`default_nettype none

interface wc_pixel_if import wc_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wc_result_if import wc_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/wc_ctrl.sv */
// wc_ctrl: state machine sequencing accumulate, divide and result hand-off.
// Depends on wc_pkg.
`default_nettype none

module wc_ctrl import wc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_last,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t              state, state_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;
  logic                out_valid_next;
  logic                in_fire;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_ACC: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (in_last) state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_BITS'(DIV_STEPS - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.load   = 1'b1;
          state_next = ST_ACC;
        end
      end
      default: state_next = ST_ACC;
    endcase
    out_valid_next = cmd.load ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

`ifndef SYNTHESIS
  a_last_starts_div: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_last |=> state == ST_INIT)
    else $error("last item did not start the division");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> cnt < CNT_BITS'(DIV_STEPS))
    else $error("division step count out of range");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the hand-off state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state == ST_INIT || state == ST_DIV |-> !in_ready)
    else $error("item accepted while dividing");
`endif

endmodule

`default_nettype wire

/* design/wc_dp.sv */
// wc_dp: saturating accumulators, two restoring dividers sharing one
// sequence, and the result register. Depends on wc_pkg.
`default_nettype none

module wc_dp import wc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  pixel_t  pixel,
  output result_t result
);

  logic [SUM_XY_BITS-1:0] sum_weighted_x, sum_weighted_y;
  logic [SUM_W_BITS-1:0]  sum_weight;
  logic [SUM_W_BITS-1:0]  divisor;
  logic [SUM_W_BITS-1:0]  rem_x, rem_y;
  logic [OUT_BITS-1:0]    lo_x, lo_y;
  logic [OUT_BITS-1:0]    quo_x, quo_y;
  logic                   empty, sat_x, sat_y;

  logic [PROD_BITS-1:0]   prod_x, prod_y;
  logic [SUM_XY_BITS:0]   add_x, add_y;
  logic [SUM_W_BITS:0]    add_w;
  logic [DIVD_BITS-1:0]   divd_x, divd_y;
  logic [SUM_W_BITS:0]    step_x, step_y;

  // one restoring step: bit 0 of the result is the quotient bit
  function automatic logic [SUM_W_BITS:0] div_step(
    input logic [SUM_W_BITS-1:0] rem,
    input logic                  dbit,
    input logic [SUM_W_BITS-1:0] dvs
  );
    logic [SUM_W_BITS:0]   shifted;
    logic [SUM_W_BITS+1:0] diff;
    shifted = {rem, dbit};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    if (diff[SUM_W_BITS+1]) return {shifted[SUM_W_BITS-1:0], 1'b0};
    else return {diff[SUM_W_BITS-1:0], 1'b1};
  endfunction

  assign prod_x = PROD_BITS'(pixel.brightness) * PROD_BITS'(pixel.pixel_x);
  assign prod_y = PROD_BITS'(pixel.brightness) * PROD_BITS'(pixel.pixel_y);
  assign add_x  = {1'b0, sum_weighted_x} + (SUM_XY_BITS+1)'(prod_x);
  assign add_y  = {1'b0, sum_weighted_y} + (SUM_XY_BITS+1)'(prod_y);
  assign add_w  = {1'b0, sum_weight} + (SUM_W_BITS+1)'(pixel.brightness);

  assign divd_x = {sum_weighted_x, {FRAC_BITS{1'b0}}};
  assign divd_y = {sum_weighted_y, {FRAC_BITS{1'b0}}};

  assign step_x = div_step(rem_x, lo_x[OUT_BITS-1], divisor);
  assign step_y = div_step(rem_y, lo_y[OUT_BITS-1], divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_weighted_x <= '0;
      sum_weighted_y <= '0;
      sum_weight     <= '0;
    end else if (cmd.acc) begin
      sum_weighted_x <= add_x[SUM_XY_BITS] ? '1 : add_x[SUM_XY_BITS-1:0];
      sum_weighted_y <= add_y[SUM_XY_BITS] ? '1 : add_y[SUM_XY_BITS-1:0];
      sum_weight     <= add_w[SUM_W_BITS] ? '1 : add_w[SUM_W_BITS-1:0];
    end else if (cmd.init) begin
      sum_weighted_x <= '0;
      sum_weighted_y <= '0;
      sum_weight     <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      divisor <= sum_weight;
      empty   <= (sum_weight == '0);
      // quotient too wide when dividend >= divisor << OUT_BITS
      sat_x   <= {1'b0, divd_x} >= (DIVD_BITS+1)'({sum_weight, {OUT_BITS{1'b0}}});
      sat_y   <= {1'b0, divd_y} >= (DIVD_BITS+1)'({sum_weight, {OUT_BITS{1'b0}}});
      rem_x   <= divd_x[OUT_BITS+SUM_W_BITS-1:OUT_BITS];
      rem_y   <= divd_y[OUT_BITS+SUM_W_BITS-1:OUT_BITS];
      lo_x    <= divd_x[OUT_BITS-1:0];
      lo_y    <= divd_y[OUT_BITS-1:0];
      quo_x   <= '0;
      quo_y   <= '0;
    end else if (cmd.step) begin
      rem_x <= step_x[SUM_W_BITS:1];
      rem_y <= step_y[SUM_W_BITS:1];
      lo_x  <= {lo_x[OUT_BITS-2:0], 1'b0};
      lo_y  <= {lo_y[OUT_BITS-2:0], 1'b0};
      quo_x <= {quo_x[OUT_BITS-2:0], step_x[0]};
      quo_y <= {quo_y[OUT_BITS-2:0], step_y[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result.empty_flag <= empty;
      result.centroid_x <= empty ? '0 : (sat_x ? '1 : quo_x);
      result.centroid_y <= empty ? '0 : (sat_y ? '1 : quo_y);
    end
  end

endmodule

`default_nettype wire

/* design/weighted_centroid.sv */
// weighted_centroid: top level, joins the controller and the datapath.
// Depends on wc_pkg, wc_ifs, wc_ctrl and wc_dp.
//
// Intensity-weighted centroid of a pixel cluster. Pixel items are taken
// one per cycle while the block accumulates brightness*x, brightness*y and
// brightness into saturating sums. The item flagged last_pixel closes the
// cluster: the block then holds pixel_in.ready low through a set-up state,
// the division steps of the two restoring dividers (one quotient bit per cycle
// for x and y together), and a hand-off state that loads the result register.
// The load waits, and ready stays low, for as long as the previous result
// is still unread. The result waits in its own register; accumulation of
// the next cluster goes on while it is unread. An empty cluster (zero
// brightness sum) gives zero coordinates with empty_flag set.
`default_nettype none

module weighted_centroid import wc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  wc_pixel_if.sink           pixel_in,
  wc_result_if.source        result_out
);

  cmd_t cmd;

  wc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel_in.valid),
    .in_last   (pixel_in.data.last_pixel),
    .in_ready  (pixel_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .cmd       (cmd)
  );

  wc_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .pixel  (pixel_in.data),
    .result (result_out.data)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// tb: self-checking testbench for weighted_centroid, pixel items in, centroid items out.
// Depends on wc_pkg and the wc_ifs interfaces; expected centroids come from a predictor.

module tb;
  import wc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1430;
  localparam int unsigned HOLD_OFF     = 400;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned N_DIRECTED   = 20;
  localparam logic [DIVD_BITS-1:0] CENTROID_CAP = DIVD_BITS'((1 << OUT_BITS) - 1);

  typedef struct packed {
    pixel_t  px;
    logic    typed_in;
    result_t res;
  } stim_row_t;

  // typed rows carry their centroid, the others are left to the predictor
  stim_row_t directed_rows [N_DIRECTED] = '{
    // empty cluster straight after reset
    '{'{11'd2047, 11'd2047, 8'd0,   1'b1}, 1'b1, '{19'd0,      19'd0,      1'b1}},
    '{'{11'd2047, 11'd2047, 8'd255, 1'b1}, 1'b1, '{19'd524032, 19'd524032, 1'b0}},
    '{'{11'd0,    11'd0,    8'd255, 1'b1}, 1'b1, '{19'd0,      19'd0,      1'b0}},
    '{'{11'd2047, 11'd0,    8'd1,   1'b1}, 1'b1, '{19'd524032, 19'd0,      1'b0}},
    '{'{11'd1,    11'd2,    8'd255, 1'b1}, 1'b1, '{19'd256,    19'd512,    1'b0}},
    // cluster of dark pixels only
    '{'{11'd5,    11'd9,    8'd0,   1'b0}, 1'b0, '0},
    '{'{11'd7,    11'd3,    8'd0,   1'b0}, 1'b0, '0},
    '{'{11'd9,    11'd1,    8'd0,   1'b1}, 1'b1, '{19'd0,      19'd0,      1'b1}},
    // quotient truncates: 256/3
    '{'{11'd0,    11'd0,    8'd2,   1'b0}, 1'b0, '0},
    '{'{11'd1,    11'd1,    8'd1,   1'b1}, 1'b1, '{19'd85,     19'd85,     1'b0}},
    // dark pixel still closes a lit cluster
    '{'{11'd100,  11'd200,  8'd3,   1'b0}, 1'b0, '0},
    '{'{11'd2047, 11'd0,    8'd0,   1'b1}, 1'b0, '0},
    '{'{11'h555,  11'h2aa,  8'haa,  1'b0}, 1'b0, '0},
    '{'{11'h2aa,  11'h555,  8'h55,  1'b0}, 1'b0, '0},
    '{'{11'd2047, 11'd2047, 8'd255, 1'b0}, 1'b0, '0},
    '{'{11'd0,    11'd0,    8'd255, 1'b1}, 1'b0, '0},
    '{'{11'd1024, 11'd1023, 8'd128, 1'b0}, 1'b0, '0},
    '{'{11'd1023, 11'd1024, 8'd127, 1'b1}, 1'b0, '0},
    '{'{11'd0,    11'd2047, 8'd255, 1'b0}, 1'b0, '0},
    '{'{11'd2047, 11'd0,    8'd255, 1'b1}, 1'b1, '{19'd262016, 19'd262016, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  wc_pixel_if  pixel_in ();
  wc_result_if result_out ();

  weighted_centroid dut (
    .clk        (clk),
    .rst        (rst),
    .pixel_in   (pixel_in),
    .result_out (result_out)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [SUM_XY_BITS-1:0] wsum_x = '0;
  logic [SUM_XY_BITS-1:0] wsum_y = '0;
  logic [SUM_W_BITS-1:0]  wsum   = '0;

  result_t     pending_centroids [$];
  result_t     oldest_centroid;
  int unsigned error_count     = 0;
  int unsigned pixels_accepted = 0;
  int unsigned clusters_closed = 0;
  int unsigned empty_clusters  = 0;
  int unsigned centroids_seen  = 0;
  int unsigned random_items    = 0;
  int unsigned burst_left      = 0;
  int unsigned cycle_count     = 0;
  bit          hold_off_request = 1'b0;

  function automatic logic [OUT_BITS-1:0] scaled_mean(logic [SUM_XY_BITS-1:0] s,
                                                      logic [SUM_W_BITS-1:0] w);
    logic [DIVD_BITS-1:0] quot;
    quot = {s, {FRAC_BITS{1'b0}}} / DIVD_BITS'(w);
    return (quot > CENTROID_CAP) ? '1 : quot[OUT_BITS-1:0];
  endfunction

  task automatic accumulate_pixel(input pixel_t p, output bit closes, output result_t res);
    logic [PROD_BITS-1:0]  prod_x;
    logic [PROD_BITS-1:0]  prod_y;
    logic [SUM_XY_BITS:0]  next_x;
    logic [SUM_XY_BITS:0]  next_y;
    logic [SUM_W_BITS:0]   next_w;
    prod_x = PROD_BITS'(p.brightness) * PROD_BITS'(p.pixel_x);
    prod_y = PROD_BITS'(p.brightness) * PROD_BITS'(p.pixel_y);
    next_x = {1'b0, wsum_x} + (SUM_XY_BITS+1)'(prod_x);
    next_y = {1'b0, wsum_y} + (SUM_XY_BITS+1)'(prod_y);
    next_w = {1'b0, wsum} + (SUM_W_BITS+1)'(p.brightness);
    // sums stick at all ones once they overflow
    wsum_x = next_x[SUM_XY_BITS] ? '1 : next_x[SUM_XY_BITS-1:0];
    wsum_y = next_y[SUM_XY_BITS] ? '1 : next_y[SUM_XY_BITS-1:0];
    wsum   = next_w[SUM_W_BITS] ? '1 : next_w[SUM_W_BITS-1:0];
    closes = p.last_pixel;
    res = '0;
    if (closes) begin
      if (wsum == '0) begin
        res.empty_flag = 1'b1;
      end else begin
        res.centroid_x = scaled_mean(wsum_x, wsum);
        res.centroid_y = scaled_mean(wsum_y, wsum);
      end
      wsum_x = '0;
      wsum_y = '0;
      wsum   = '0;
    end
  endtask

  // called at a falling edge, returns at the next falling edge after acceptance
  task automatic send_pixel(input pixel_t p, input bit typed_in, input result_t typed_res);
    bit      closes;
    result_t predicted;
    result_t want;
    pixel_in.valid <= 1'b1;
    pixel_in.data  <= p;
    do @(posedge clk); while (!pixel_in.ready);
    accumulate_pixel(p, closes, predicted);
    pixels_accepted++;
    if (closes) begin
      want = typed_in ? typed_res : predicted;
      pending_centroids.insert(pending_centroids.size(), want);
      clusters_closed++;
      if (want.empty_flag) empty_clusters++;
    end
    @(negedge clk);
  endtask

  // bursts of random length with random gaps
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      pixel_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic send_random_cluster();
    int unsigned n;
    int unsigned sel;
    int unsigned style;
    int unsigned cx;
    int unsigned cy;
    int unsigned vx;
    int unsigned vy;
    pixel_t      p;
    sel = $urandom_range(0, 99);
    if (sel < 78)      n = $urandom_range(1, 8);
    else if (sel < 98) n = $urandom_range(9, 64);
    else               n = $urandom_range(65, 400);
    style = $urandom_range(0, 9);
    cx = $urandom_range(0, 2047);
    cy = $urandom_range(0, 2047);
    for (int unsigned i = 0; i < n; i++) begin
      if (style == 1) begin
        vx = $urandom_range(0, 2047);
        vy = $urandom_range(0, 2047);
      end else begin
        // a compact blob, clipped at the frame edge
        vx = cx + $urandom_range(0, 24);
        vy = cy + $urandom_range(0, 24);
        if (vx > 2047) vx = 2047;
        if (vy > 2047) vy = 2047;
      end
      p.pixel_x = COORD_BITS'(vx);
      p.pixel_y = COORD_BITS'(vy);
      if (style == 0 || $urandom_range(0, 7) == 0)
        p.brightness = '0;
      else if ($urandom_range(0, 3) == 0)
        p.brightness = '1;
      else
        p.brightness = BRIGHT_BITS'($urandom_range(1, 254));
      p.last_pixel = (i == n - 1);
      send_pixel(p, 1'b0, '0);
      random_items++;
      pace_sender();
    end
  endtask

  // receiver: stall pattern picks a new random mode after each random span, one long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned span;
    result_out.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        if (hold_off_request) begin
          hold_off_request = 1'b0;
          result_out.ready <= 1'b0;
          repeat (HOLD_OFF) @(negedge clk);
        end
        case (mode)
          0: begin
            result_out.ready <= 1'b1;
          end
          1: begin
            result_out.ready <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            result_out.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            result_out.ready <= ~result_out.ready;
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_out.valid && result_out.ready) begin
      if (pending_centroids.size() == 0) begin
        $error("centroid item with none expected: x %0d y %0d empty %0d",
               result_out.data.centroid_x, result_out.data.centroid_y,
               result_out.data.empty_flag);
        error_count++;
      end else begin
        oldest_centroid = pending_centroids.pop_front();
        centroids_seen++;
        if (result_out.data.centroid_x !== oldest_centroid.centroid_x) begin
          $error("centroid_x mismatch: expected %0d, actual %0d",
                 oldest_centroid.centroid_x, result_out.data.centroid_x);
          error_count++;
        end
        if (result_out.data.centroid_y !== oldest_centroid.centroid_y) begin
          $error("centroid_y mismatch: expected %0d, actual %0d",
                 oldest_centroid.centroid_y, result_out.data.centroid_y);
          error_count++;
        end
        if (result_out.data.empty_flag !== oldest_centroid.empty_flag) begin
          $error("empty_flag mismatch: expected %0d, actual %0d",
                 oldest_centroid.empty_flag, result_out.data.empty_flag);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d centroid items outstanding",
               cycle_count, pending_centroids.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned cluster_idx;
    pixel_in.valid = 1'b0;
    pixel_in.data  = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].px, directed_rows[i].typed_in, directed_rows[i].res);
      pace_sender();
    end

    // receiver holds off while clusters keep coming, so the block backs up
    hold_off_request = 1'b1;
    cluster_idx = 0;
    while (random_items < RANDOM_ITEMS) begin
      send_random_cluster();
      cluster_idx++;
      if (cluster_idx % 40 == 39) begin
        pixel_in.valid <= 1'b0;
        while (pending_centroids.size() != 0) @(negedge clk);
      end
    end

    pixel_in.valid <= 1'b0;
    while (pending_centroids.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run covered %0d pixel items in %0d clusters, %0d of them empty",
             pixels_accepted, clusters_closed, empty_clusters);
    $display("%0d centroid items compared in %0d cycles, %0d errors",
             centroids_seen, cycle_count, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/wc_pkg.sv
design/wc_ifs.sv
design/wc_ctrl.sv
design/wc_dp.sv
design/weighted_centroid.sv
tb/tb.sv
